>>> rtl/core/emx_pkg.sv
// ---------------------------------------------------------------------------
// emx_pkg: shared constants and types of the modular exponentiation unit
// Port widths, register map codes and register reset values.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package emx_pkg;

    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;
    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 32;
    localparam int REG_LSB    = 2;

    typedef enum logic [1:0] {
        REG_ENC_EXP = 2'd0,
        REG_ENC_MOD = 2'd1,
        REG_DEC_EXP = 2'd2,
        REG_DEC_MOD = 2'd3
    } t_reg_idx;

    localparam logic [31:0] ENC_EXP_RST = 32'd7;
    localparam logic [31:0] ENC_MOD_RST = 32'd95477;
    localparam logic [31:0] DEC_EXP_RST = 32'd38291;
    localparam logic [31:0] DEC_MOD_RST = 32'd84823;

endpackage

`default_nettype wire

>>> rtl/core/emx_modmul.sv
// ---------------------------------------------------------------------------
// emx_modmul: shift-and-add modular multiplier
// Scans x from its top bit, one bit a cycle: r = 2r + x_bit*y, reduced
// below m by one compare against m and 2m. Needs y < m; y and m held stable.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module emx_modmul #(
    parameter int X_BITS   = 32,
    parameter int MOD_BITS = 31
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [X_BITS-1:0]   i_x,
    input  wire logic [MOD_BITS-1:0] i_y,
    input  wire logic [MOD_BITS-1:0] i_m,
    output logic                     o_done,
    output logic [MOD_BITS-1:0]      o_r
);

    localparam int CNT_W = $clog2(X_BITS + 1);
    localparam int T_W   = MOD_BITS + 2;

    logic [X_BITS-1:0]   r_x;
    logic [MOD_BITS-1:0] r_r;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_done;

    logic [X_BITS-1:0]   n_x;
    logic [MOD_BITS-1:0] n_r;
    logic [T_W-1:0]      w_sum;
    logic [T_W-1:0]      w_m1;
    logic [T_W-1:0]      w_m2;
    logic [T_W-1:0]      w_red;

    always_comb begin
        n_x   = r_x << 1;
        w_m1  = {2'b00, i_m};
        w_m2  = {1'b0, i_m, 1'b0};
        w_sum = {1'b0, r_r, 1'b0} + (r_x[X_BITS-1] ? {2'b00, i_y} : {T_W{1'b0}});
        if (w_sum >= w_m2) begin
            w_red = w_sum - w_m2;
        end else if (w_sum >= w_m1) begin
            w_red = w_sum - w_m1;
        end else begin
            w_red = w_sum;
        end
        n_r = w_red[MOD_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_x   <= i_x;
                r_r   <= '0;
                r_cnt <= CNT_W'(X_BITS);
            end else if (r_cnt != '0) begin
                r_x   <= n_x;
                r_r   <= n_r;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_r    = r_r;

endmodule

`default_nettype wire

>>> rtl/core/emx_cell.sv
// ---------------------------------------------------------------------------
// emx_cell: one exponent bit of the square-and-multiply chain
// Takes (acc, sq, m, e), multiplies acc by sq when e[0] is set, squares sq,
// and hands the word on with e shifted down. A cleared e passes straight on.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module emx_cell #(
    parameter int MOD_BITS = 31,
    parameter int EXP_BITS = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [MOD_BITS-1:0] i_acc,
    input  wire logic [MOD_BITS-1:0] i_sq,
    input  wire logic [MOD_BITS-1:0] i_m,
    input  wire logic [EXP_BITS-1:0] i_e,
    input  wire logic                i_zero,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [MOD_BITS-1:0]      o_acc,
    output logic [MOD_BITS-1:0]      o_sq,
    output logic [MOD_BITS-1:0]      o_m,
    output logic [EXP_BITS-1:0]      o_e,
    output logic                     o_zero
);

    typedef enum logic [1:0] {
        S_EMPTY,
        S_CALC,
        S_DONE
    } t_state;

    t_state              r_state;
    logic                r_start;
    logic [MOD_BITS-1:0] r_acc;
    logic [MOD_BITS-1:0] r_sq;
    logic [MOD_BITS-1:0] r_m;
    logic [EXP_BITS-1:0] r_e;
    logic                r_zero;

    logic                w_done;
    logic                w_sq_done;
    logic [MOD_BITS-1:0] w_acc_prod;
    logic [MOD_BITS-1:0] w_sq_prod;

    emx_modmul #(
        .X_BITS   (MOD_BITS),
        .MOD_BITS (MOD_BITS)
    ) u_mul_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_x     (r_sq),
        .i_y     (r_acc),
        .i_m     (r_m),
        .o_done  (w_done),
        .o_r     (w_acc_prod)
    );

    emx_modmul #(
        .X_BITS   (MOD_BITS),
        .MOD_BITS (MOD_BITS)
    ) u_mul_sq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_x     (r_sq),
        .i_y     (r_sq),
        .i_m     (r_m),
        .o_done  (w_sq_done),
        .o_r     (w_sq_prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_EMPTY;
            r_start <= 1'b0;
        end else begin
            r_start <= 1'b0;
            unique case (r_state)
                S_EMPTY: begin
                    if (i_valid) begin
                        r_acc  <= i_acc;
                        r_sq   <= i_sq;
                        r_m    <= i_m;
                        r_e    <= i_e;
                        r_zero <= i_zero;
                        if (i_e == '0) begin
                            r_state <= S_DONE;
                        end else begin
                            r_start <= 1'b1;
                            r_state <= S_CALC;
                        end
                    end
                end
                S_CALC: begin
                    if (w_done && w_sq_done) begin
                        if (r_e[0]) begin
                            r_acc <= w_acc_prod;
                        end
                        r_sq    <= w_sq_prod;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_ready) begin
                        r_state <= S_EMPTY;
                    end
                end
                default: r_state <= S_EMPTY;
            endcase
        end
    end

    assign o_ready = (r_state == S_EMPTY);
    assign o_valid = (r_state == S_DONE);
    assign o_acc   = r_acc;
    assign o_sq    = r_sq;
    assign o_m     = r_m;
    assign o_e     = r_e >> 1;
    assign o_zero  = r_zero;

endmodule

`default_nettype wire

>>> rtl/core/modular_exponentiation_unit.sv
// ---------------------------------------------------------------------------
// modular_exponentiation_unit: base^e mod m, right-to-left square-and-multiply
// A word on the slave stream (tdata = base, tuser = func) picks the encrypt
// (func 0) or decrypt (func 1) key pair from the APB registers and returns
// base^e mod m on the master stream. The base is first reduced mod m by a
// shift-add front stage, then passes a chain of EXP_BITS cells, one per
// exponent bit; each cell runs two shift-add modular multipliers side by
// side for an exponent bit at or below the top set bit and passes the word
// straight on above it. Words follow each other down the chain, so the
// front stage takes a new word once it has handed the last one to the first
// cell, while earlier words are still in the chain. A stalled result word
// holds the chain behind it. A modulus of zero returns 0. Registers are to
// be written only while no word is in flight; the block itself does not
// enforce this.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module modular_exponentiation_unit #(
    parameter int MOD_BITS = 31,
    parameter int EXP_BITS = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // slave stream
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [emx_pkg::IN_DATA_W-1:0] s_axis_tdata,  // [31:0] base
    input  wire logic [emx_pkg::IN_USER_W-1:0] s_axis_tuser,  // [0] func
    // master stream
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [emx_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // [30:0] power_mod
    // APB register port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [emx_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [emx_pkg::PDATA_W-1:0]   pwdata,
    output logic [emx_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready
);

    typedef enum logic [1:0] {
        F_EMPTY,
        F_CALC,
        F_DONE
    } t_fstate;

    logic [EXP_BITS-1:0] r_enc_exp;
    logic [MOD_BITS-1:0] r_enc_mod;
    logic [EXP_BITS-1:0] r_dec_exp;
    logic [MOD_BITS-1:0] r_dec_mod;

    t_fstate                     r_fstate;
    logic                        r_fstart;
    logic [emx_pkg::IN_DATA_W-1:0] r_base;
    logic [MOD_BITS-1:0]         r_m;
    logic [EXP_BITS-1:0]         r_e;
    logic                        r_zero;
    logic [MOD_BITS-1:0]         r_fsq;

    logic                        w_fdone;
    logic [MOD_BITS-1:0]         w_fred;
    logic [MOD_BITS-1:0]         w_one;
    logic                        w_wr;
    emx_pkg::t_reg_idx           w_idx;

    logic                        w_valid [EXP_BITS+1];
    logic                        w_ready [EXP_BITS+1];
    logic [MOD_BITS-1:0]         w_acc   [EXP_BITS+1];
    logic [MOD_BITS-1:0]         w_sq    [EXP_BITS+1];
    logic [MOD_BITS-1:0]         w_m     [EXP_BITS+1];
    logic [EXP_BITS-1:0]         w_e     [EXP_BITS+1];
    logic                        w_zero  [EXP_BITS+1];

    // register port
    assign w_idx  = emx_pkg::t_reg_idx'(paddr[emx_pkg::PADDR_W-1:emx_pkg::REG_LSB]);
    assign w_wr   = psel & penable & pwrite & pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enc_exp <= emx_pkg::ENC_EXP_RST[EXP_BITS-1:0];
            r_enc_mod <= emx_pkg::ENC_MOD_RST[MOD_BITS-1:0];
            r_dec_exp <= emx_pkg::DEC_EXP_RST[EXP_BITS-1:0];
            r_dec_mod <= emx_pkg::DEC_MOD_RST[MOD_BITS-1:0];
        end else if (w_wr) begin
            unique case (w_idx)
                emx_pkg::REG_ENC_EXP: r_enc_exp <= pwdata[EXP_BITS-1:0];
                emx_pkg::REG_ENC_MOD: r_enc_mod <= pwdata[MOD_BITS-1:0];
                emx_pkg::REG_DEC_EXP: r_dec_exp <= pwdata[EXP_BITS-1:0];
                emx_pkg::REG_DEC_MOD: r_dec_mod <= pwdata[MOD_BITS-1:0];
                default: r_enc_exp <= r_enc_exp;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            emx_pkg::REG_ENC_EXP: prdata = emx_pkg::PDATA_W'(r_enc_exp);
            emx_pkg::REG_ENC_MOD: prdata = emx_pkg::PDATA_W'(r_enc_mod);
            emx_pkg::REG_DEC_EXP: prdata = emx_pkg::PDATA_W'(r_dec_exp);
            emx_pkg::REG_DEC_MOD: prdata = emx_pkg::PDATA_W'(r_dec_mod);
            default:              prdata = '0;
        endcase
    end

    // front stage: latch key pair, reduce base mod m
    assign w_one = (r_m == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);

    emx_modmul #(
        .X_BITS   (emx_pkg::IN_DATA_W),
        .MOD_BITS (MOD_BITS)
    ) u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_fstart),
        .i_x     (r_base),
        .i_y     (w_one),
        .i_m     (r_m),
        .o_done  (w_fdone),
        .o_r     (w_fred)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fstate <= F_EMPTY;
            r_fstart <= 1'b0;
        end else begin
            r_fstart <= 1'b0;
            unique case (r_fstate)
                F_EMPTY: begin
                    if (s_axis_tvalid) begin
                        r_base   <= s_axis_tdata;
                        r_m      <= s_axis_tuser[0] ? r_dec_mod : r_enc_mod;
                        r_e      <= s_axis_tuser[0] ? r_dec_exp : r_enc_exp;
                        r_zero   <= s_axis_tuser[0] ? (r_dec_mod == '0) : (r_enc_mod == '0);
                        r_fstart <= 1'b1;
                        r_fstate <= F_CALC;
                    end
                end
                F_CALC: begin
                    if (w_fdone) begin
                        r_fsq    <= w_fred;
                        r_fstate <= F_DONE;
                    end
                end
                F_DONE: begin
                    if (w_ready[0]) begin
                        r_fstate <= F_EMPTY;
                    end
                end
                default: r_fstate <= F_EMPTY;
            endcase
        end
    end

    assign s_axis_tready = (r_fstate == F_EMPTY);

    assign w_valid[0] = (r_fstate == F_DONE);
    assign w_acc[0]   = w_one;
    assign w_sq[0]    = r_fsq;
    assign w_m[0]     = r_m;
    assign w_e[0]     = r_e;
    assign w_zero[0]  = r_zero;

    // one cell per exponent bit
    for (genvar g = 0; g < EXP_BITS; g++) begin : g_cell
        emx_cell #(
            .MOD_BITS (MOD_BITS),
            .EXP_BITS (EXP_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_acc   (w_acc[g]),
            .i_sq    (w_sq[g]),
            .i_m     (w_m[g]),
            .i_e     (w_e[g]),
            .i_zero  (w_zero[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_acc   (w_acc[g+1]),
            .o_sq    (w_sq[g+1]),
            .o_m     (w_m[g+1]),
            .o_e     (w_e[g+1]),
            .o_zero  (w_zero[g+1])
        );
    end

    // last cell holds the result word until taken
    assign w_ready[EXP_BITS] = m_axis_tready;
    assign m_axis_tvalid     = w_valid[EXP_BITS];
    assign m_axis_tdata      = w_zero[EXP_BITS] ? '0
                                                : emx_pkg::OUT_DATA_W'(w_acc[EXP_BITS]);

endmodule

`default_nettype wire

>>> rtl/core/emx_checker.sv
// ---------------------------------------------------------------------------
// emx_checker: port-level checks of the modular exponentiation unit
// Watches the stream ports over time; attached to the top level by bind.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module emx_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           s_axis_tvalid,
    input wire logic                           s_axis_tready,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [emx_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("front stage took a word while reducing");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result word shown right after reset");

endmodule

bind modular_exponentiation_unit emx_checker u_emx_checker (.*);

`default_nettype wire
